// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files, used by the controller (wra_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, muted during reset.
`define WRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge.
`define WRA_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/wra_pkg.sv =====
// ----------------------------------------------------------------------------
// wra_pkg
// Types, constants and controller interface for the windowed rate averager.
// ----------------------------------------------------------------------------
package wra_pkg;

    // Window arrangement: the first windows have fixed lengths, the rest
    // count since the start of the time base.
    localparam int NUM_WINDOWS   = 3;
    localparam int FIXED_WINDOWS = 2;
    localparam int WIN_W         = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 8'd1;
    localparam logic [31:0] SHORT_WINDOW_RESET = 32'd3600;
    localparam logic [31:0] LONG_WINDOW_RESET  = 32'd86400;

    // Input commands
    localparam logic CMD_AGGREGATE = 1'b0;
    localparam logic CMD_RESET     = 1'b1;

    // Divider geometry
    localparam int DIV_N   = 64;
    localparam int DIV_D   = 32;
    localparam int DIV_CNT = $clog2(DIV_N + 1);

    typedef struct packed {
        logic        command;
        logic [31:0] now_seconds;
        logic [63:0] counter_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] rate_short;
        logic [63:0] rate_long;
        logic [63:0] rate_since_start;
        logic        all_rates_zero;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic store_avg;
        logic next_win;
        logic finish;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic last_win;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== design/windowed_rate_averager_core.sv =====
// ----------------------------------------------------------------------------
// windowed_rate_averager_core
// Short, long and since-start average event rates from counter samples.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_ready  | in_data   (wra_pkg::in_item_t)
//   out     | output    | out_valid / out_ready| out_data  (wra_pkg::out_item_t)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An aggregate sample takes each window in turn through the bit-serial divider
// shared by the windows. One transaction is in work at a time; the output
// register holds a result while the next sample is taken in.
// The config port is always ready. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module windowed_rate_averager_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wra_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wra_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    wra_pkg::ctrl_cmd_t    cmd;
    wra_pkg::ctrl_status_t sts;

    assign cfg_ready = 1'b1;

    wra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_ready   (in_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    wra_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== design/wra_divider.sv =====
// ----------------------------------------------------------------------------
// wra_divider
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit unsigned.
// ----------------------------------------------------------------------------
module wra_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wra_pkg::DIV_N-1:0]    dividend,
    input  logic [wra_pkg::DIV_D-1:0]    divisor,
    output logic [wra_pkg::DIV_N-1:0]    quotient,
    output logic                         done
);

    logic [wra_pkg::DIV_N-1:0]   quo_reg, quo_next;
    logic [wra_pkg::DIV_D-1:0]   rem_reg, rem_next;
    logic [wra_pkg::DIV_D-1:0]   dsr_reg;
    logic [wra_pkg::DIV_CNT-1:0] cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [wra_pkg::DIV_D:0]     shifted;
    logic [wra_pkg::DIV_D:0]     trial;

    // One shift-subtract step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[wra_pkg::DIV_N-1]};
        trial    = shifted - {1'b0, dsr_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = wra_pkg::DIV_CNT'(wra_pkg::DIV_N);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[wra_pkg::DIV_D])
            begin
                rem_next = trial[wra_pkg::DIV_D-1:0];
                quo_next = {quo_reg[wra_pkg::DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[wra_pkg::DIV_D-1:0];
                quo_next = {quo_reg[wra_pkg::DIV_N-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == wra_pkg::DIV_CNT'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dsr_reg <= divisor;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== design/wra_datapath.sv =====
// ----------------------------------------------------------------------------
// wra_datapath
// Window state, split multiplier, accumulator, shared divider and output reg.
// ----------------------------------------------------------------------------
module wra_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wra_pkg::ctrl_cmd_t               cmd,
    output wra_pkg::ctrl_status_t            sts,
    input  wra_pkg::in_item_t                in_data,
    input  logic                             cfg_we,
    input  logic [wra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output wra_pkg::out_item_t               out_data
);

    // Configuration
    logic [31:0] short_len_reg;
    logic [31:0] long_len_reg;

    // Time base and per-window state
    logic [31:0] start_time_reg;
    logic [31:0] prev_time_reg;
    logic [63:0] seen_count_reg [wra_pkg::NUM_WINDOWS];
    logic [63:0] sum_reg        [wra_pkg::NUM_WINDOWS];
    logic [63:0] avg_reg        [wra_pkg::NUM_WINDOWS];

    // Per-sample working registers
    logic [31:0]              now_reg;
    logic [63:0]              count_reg;
    logic [31:0]              elapsed_reg;
    logic [31:0]              interval_reg;
    logic [wra_pkg::WIN_W-1:0] win_reg;
    logic [63:0]              prod_lo_reg;
    logic [31:0]              prod_hi_reg;
    logic [63:0]              delta_reg;

    logic                     out_valid_reg;
    wra_pkg::out_item_t       out_data_reg;

    logic [31:0] elapsed_next;
    logic [31:0] interval_next;
    logic        fixed;
    logic [31:0] win_len;
    logic        filling;
    logic [63:0] avg_cur;
    logic [63:0] sum_new;
    logic [31:0] divisor;
    logic [63:0] quotient;
    logic        div_done;
    logic [63:0] rate0, rate1, rate2;

    function automatic logic [63:0] rate_of(input int w,
                                            input logic [63:0] a [wra_pkg::NUM_WINDOWS]);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < wra_pkg::NUM_WINDOWS; i++)
            if (i == w)
                r = a[i];
        return r;
    endfunction

    // Elapsed time and interval, clamped at zero when time runs backwards
    always_comb
    begin
        elapsed_next  = (in_data.now_seconds >= start_time_reg) ?
                        in_data.now_seconds - start_time_reg : '0;
        interval_next = (in_data.now_seconds >= prev_time_reg) ?
                        in_data.now_seconds - prev_time_reg : '0;
    end

    // Window under work: length and fill phase
    always_comb
    begin
        fixed   = (32'(win_reg) < 32'(wra_pkg::FIXED_WINDOWS));
        win_len = (win_reg == '0) ? short_len_reg : long_len_reg;
        filling = !fixed || (elapsed_reg <= win_len);
        avg_cur = avg_reg[win_reg];
        sum_new = sum_reg[win_reg] + delta_reg -
                  (filling ? 64'd0 : {prod_hi_reg, 32'd0});
        divisor = filling ? elapsed_reg : win_len;
        if (divisor == '0)
            divisor = 32'd1;
    end

    wra_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.acc),
        .dividend (sum_new),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_len_reg <= wra_pkg::SHORT_WINDOW_RESET;
            long_len_reg  <= wra_pkg::LONG_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wra_pkg::CFG_SHORT_WINDOW: short_len_reg <= cfg_data;
                wra_pkg::CFG_LONG_WINDOW:  long_len_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Model state: time base and windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            prev_time_reg  <= '0;
            for (int i = 0; i < wra_pkg::NUM_WINDOWS; i++)
            begin
                seen_count_reg[i] <= '0;
                sum_reg[i]        <= '0;
                avg_reg[i]        <= '0;
            end
        end
        else
        begin
            if (cmd.latch_in && in_data.command == wra_pkg::CMD_RESET)
            begin
                start_time_reg <= in_data.now_seconds;
                prev_time_reg  <= '0;
                for (int i = 0; i < wra_pkg::NUM_WINDOWS; i++)
                begin
                    seen_count_reg[i] <= '0;
                    sum_reg[i]        <= '0;
                    avg_reg[i]        <= '0;
                end
            end
            if (cmd.mul_hi)
                seen_count_reg[win_reg] <= count_reg;
            if (cmd.acc)
                sum_reg[win_reg] <= sum_new;
            if (cmd.store_avg)
                avg_reg[win_reg] <= quotient;
            if (cmd.finish)
                prev_time_reg <= now_reg;
        end
    end

    // Working registers for the current sample
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            now_reg      <= in_data.now_seconds;
            count_reg    <= in_data.counter_value;
            elapsed_reg  <= elapsed_next;
            interval_reg <= interval_next;
        end
        if (cmd.mul_lo)
            prod_lo_reg <= 64'(avg_cur[31:0]) * 64'(interval_reg);
        if (cmd.mul_hi)
        begin
            prod_hi_reg <= 32'(avg_cur[63:32] * interval_reg);
            delta_reg   <= count_reg - seen_count_reg[win_reg] -
                           (filling ? 64'd0 : prod_lo_reg);
        end
    end

    // Window index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (cmd.latch_in)
            win_reg <= '0;
        else if (cmd.next_win)
            win_reg <= win_reg + 1'b1;
    end

    // Output register
    always_comb
    begin
        rate0 = rate_of(0, avg_reg);
        rate1 = rate_of(1, avg_reg);
        rate2 = rate_of(2, avg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.rate_short       <= rate0;
            out_data_reg.rate_long        <= rate1;
            out_data_reg.rate_since_start <= rate2;
            out_data_reg.all_rates_zero   <= (rate0 == '0) && (rate1 == '0) && (rate2 == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status to controller
    assign sts.div_done = div_done;
    assign sts.last_win = (32'(win_reg) == 32'(wra_pkg::NUM_WINDOWS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

// ===== design/wra_ctrl.sv =====
// ----------------------------------------------------------------------------
// wra_ctrl
// Sequencer: walks each window through multiply, accumulate and divide.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wra_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    output logic                  in_ready,
    input  wra_pkg::ctrl_status_t sts,
    output wra_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_MUL_LO   = 6'b000010,
        S_MUL_HI   = 6'b000100,
        S_ACC      = 6'b001000,
        S_DIV_WAIT = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = (in_command == wra_pkg::CMD_RESET) ? S_DONE : S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.store_avg = 1'b1;
                    if (sts.last_win)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.next_win = 1'b1;
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Checks
    `WRA_ASSERT(a_div_done_in_wait, sts.div_done |-> state_reg == S_DIV_WAIT, "divider finished outside wait state")
    `WRA_ASSERT(a_load_needs_slot, cmd.load_out |-> sts.out_free, "result loaded over a pending one")
    `WRA_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> state_reg != S_IDLE, "accepted transaction dropped")

endmodule

// ===== test/wra_rate_checker.sv =====
// ----------------------------------------------------------------------------
// wra_rate_checker
// Watches the input, output and config channels of the rate averager,
// keeps its own copy of the window state, and checks every result
// transaction field by field against the oldest predicted rate set.
// ----------------------------------------------------------------------------
module wra_rate_checker
    import wra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   failures,
    output int                   pending,
    output int                   checked,
    output int                   full_window_samples
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 40;

    // Shadow copy of the block's configuration and window state
    logic [31:0] short_len;
    logic [31:0] long_len;
    logic [31:0] base_time;
    logic [31:0] last_sample_time;
    logic [63:0] seen_count [NUM_WINDOWS];
    logic [63:0] win_sum    [NUM_WINDOWS];
    logic [63:0] win_avg    [NUM_WINDOWS];

    out_item_t predicted_rates [$];
    int        mismatches;
    int        results_seen;
    int        decayed;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advance the window state by one transaction and return the rate set
    function automatic out_item_t compute_rates(input in_item_t item);
        logic [63:0] elapsed;
        logic [63:0] interval;
        logic [63:0] len;
        logic [63:0] delta;
        logic [63:0] divisor;
        logic [63:0] rate [3];
        logic        fixed_len;
        logic        filling;
        logic        any_full;
        out_item_t   res;
        any_full = 1'b0;
        if (item.command == CMD_RESET) begin
            base_time        = item.now_seconds;
            last_sample_time = '0;
            for (int w = 0; w < NUM_WINDOWS; w++) begin
                seen_count[w] = '0;
                win_sum[w]    = '0;
                win_avg[w]    = '0;
            end
        end
        else begin
            // time running backwards counts as no time at all
            elapsed  = (item.now_seconds >= base_time)
                       ? {32'd0, item.now_seconds - base_time} : 64'd0;
            interval = (item.now_seconds >= last_sample_time)
                       ? {32'd0, item.now_seconds - last_sample_time} : 64'd0;
            for (int w = 0; w < NUM_WINDOWS; w++) begin
                fixed_len = (w == 0) || (w == 1);
                len       = (w == 0) ? {32'd0, short_len} :
                            (w == 1) ? {32'd0, long_len}  : 64'd0;
                filling   = !fixed_len || (elapsed <= len);
                delta     = item.counter_value - seen_count[w];
                seen_count[w] = item.counter_value;
                // full window: take out what the last average put in
                if (!filling) begin
                    delta    = delta - win_avg[w] * interval;
                    any_full = 1'b1;
                end
                win_sum[w] = win_sum[w] + delta;
                divisor    = filling ? elapsed : len;
                if (divisor == 64'd0)
                    divisor = 64'd1;
                win_avg[w] = win_sum[w] / divisor;
            end
            last_sample_time = item.now_seconds;
            if (any_full)
                decayed++;
        end
        for (int r = 0; r < 3; r++)
            rate[r] = (r < NUM_WINDOWS) ? win_avg[r] : 64'd0;
        res.rate_short       = rate[0];
        res.rate_long        = rate[1];
        res.rate_since_start = rate[2];
        res.all_rates_zero   = (rate[0] == 0) && (rate[1] == 0) && (rate[2] == 0);
        return res;
    endfunction

    // Channel monitor: config, then input, then output on each edge
    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            short_len        = SHORT_WINDOW_RESET;
            long_len         = LONG_WINDOW_RESET;
            base_time        = '0;
            last_sample_time = '0;
            for (int w = 0; w < NUM_WINDOWS; w++) begin
                seen_count[w] = '0;
                win_sum[w]    = '0;
                win_avg[w]    = '0;
            end
            predicted_rates.delete();
            mismatches   = 0;
            results_seen = 0;
            decayed      = 0;
            failures            <= 0;
            pending             <= 0;
            checked             <= 0;
            full_window_samples <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SHORT_WINDOW)
                    short_len = cfg_data;
                else if (cfg_index == CFG_LONG_WINDOW)
                    long_len = cfg_data;
            end
            if (in_valid && in_ready)
                predicted_rates.push_back(compute_rates(in_data));
            if (out_valid && out_ready) begin
                if (predicted_rates.size() == 0) begin
                    report("result with nothing outstanding", out_data.rate_short, 64'd0);
                end
                else begin
                    want = predicted_rates.pop_front();
                    results_seen++;
                    if (out_data.rate_short !== want.rate_short)
                        report("rate_short", out_data.rate_short, want.rate_short);
                    if (out_data.rate_long !== want.rate_long)
                        report("rate_long", out_data.rate_long, want.rate_long);
                    if (out_data.rate_since_start !== want.rate_since_start)
                        report("rate_since_start", out_data.rate_since_start,
                               want.rate_since_start);
                    if (out_data.all_rates_zero !== want.all_rates_zero)
                        report("all_rates_zero", {63'd0, out_data.all_rates_zero},
                               {63'd0, want.all_rates_zero});
                end
            end
            failures            <= mismatches;
            pending             <= predicted_rates.size();
            checked             <= results_seen;
            full_window_samples <= decayed;
        end
    end

endmodule

// ===== test/tb_windowed_rate_averager_core.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_rate_averager_core
// Drives counter samples and reset commands into the rate averager under
// several window settings, with bursty input, a stalling receiver and one
// long output hold-off; the checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb_windowed_rate_averager_core;
    import wra_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 200;
    localparam int NUM_PHASES       = 5;
    localparam int HOLD_AFTER       = 60;
    localparam int HOLD_CYCLES      = 3000;
    localparam int DRAIN_CYCLES     = 250;
    localparam int IDLE_LIMIT       = 20000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int failures;
    int pending;
    int checked;
    int full_window_samples;

    // Stimulus bookkeeping
    logic        offering    = 1'b0;
    int          burst_left  = 0;
    int          gap_max     = 20;
    int          samples_sent = 0;
    int          resets_sent  = 0;
    int          cfg_writes   = 0;
    logic [31:0] cur_short   = SHORT_WINDOW_RESET;
    logic [31:0] cur_long    = LONG_WINDOW_RESET;

    windowed_rate_averager_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wra_rate_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .in_data             (in_data),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .out_data            (out_data),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .failures            (failures),
        .pending             (pending),
        .checked             (checked),
        .full_window_samples (full_window_samples)
    );

    // Clock
    initial begin
        forever #5 clk = ~clk;
    end

    function automatic in_item_t make_item(input logic cmd, input logic [31:0] now,
                                           input logic [63:0] count);
        in_item_t it;
        it.command       = cmd;
        it.now_seconds   = now;
        it.counter_value = count;
        return it;
    endfunction

    task automatic drop_valid();
        if (offering) begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Burst pacing: after a burst, pause the sender for a random gap
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                drop_valid();
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // One input transaction; valid stays up for a following one
    task automatic push_item(input in_item_t item);
        in_data  <= item;
        in_valid <= 1'b1;
        offering = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (item.command == CMD_RESET)
            resets_sent++;
        else
            samples_sent++;
        pace();
    endtask

    // Wait for the block to drain before touching its registers
    task automatic settle();
        drop_valid();
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both window lengths back to back on the config channel
    task automatic write_windows(input logic [31:0] short_val, input logic [31:0] long_val);
        cfg_index <= CFG_SHORT_WINDOW;
        cfg_data  <= short_val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_LONG_WINDOW;
        cfg_data  <= long_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_short = short_val;
        cur_long  = long_val;
        cfg_writes += 2;
    endtask

    // Well-formed run: reset the time base, then samples with mostly rising time and an occasional step back
    task automatic run_sequence();
        logic [31:0]     t;
        logic [63:0]     c;
        longint unsigned span;
        int              len;
        t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
        c = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        case ($urandom_range(0, 2))
            0:       span = $urandom_range(1, 4);
            1:       span = longint'(cur_short) / 2 + 1;
            default: span = longint'(cur_long) / 8 + 1;
        endcase
        if (span > 200000)
            span = 200000;
        len = $urandom_range(4, 25);
        push_item(make_item(CMD_RESET, t, {$urandom, $urandom}));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0)
                t = t - $urandom_range(1, 1000);
            else
                t = t + $urandom_range(0, int'(span));
            case ($urandom_range(0, 3))
                0:       c = c;
                1:       c = c + $urandom_range(0, 1000);
                2:       c = c + $urandom;
                default: c = c + {$urandom, $urandom};
            endcase
            push_item(make_item(CMD_AGGREGATE, t, c));
        end
    endtask

    // Receiver: changing stall patterns, plus one long hold-off
    initial begin : receiver
        int   mode;
        int   mode_left;
        int   results_seen;
        logic held;
        mode         = 0;
        mode_left    = 0;
        results_seen = 0;
        held         = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                results_seen++;
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 600);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    2:       out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        int          phase_start;
        logic [31:0] short_val;
        logic [31:0] long_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset window lengths
        push_item(make_item(CMD_AGGREGATE, 32'd0, 64'd0));
        push_item(make_item(CMD_AGGREGATE, 32'd10, '1));
        push_item(make_item(CMD_RESET, 32'd1000, 64'h0123_4567_89ab_cdef));
        push_item(make_item(CMD_AGGREGATE, 32'd1000, 64'd5));
        push_item(make_item(CMD_AGGREGATE, 32'd1500, 64'd100));
        push_item(make_item(CMD_AGGREGATE, 32'd900, 64'd200));
        push_item(make_item(CMD_AGGREGATE, 32'd5000, 64'd300));
        push_item(make_item(CMD_AGGREGATE, 32'd7000, 64'd400));
        push_item(make_item(CMD_AGGREGATE, 32'd100000, 64'd0));
        push_item(make_item(CMD_AGGREGATE, '1, '1));
        push_item(make_item(CMD_RESET, '1, 64'd0));
        push_item(make_item(CMD_AGGREGATE, 32'd0, 64'd1));
        push_item(make_item(CMD_RESET, 32'd0, '1));
        push_item(make_item(CMD_AGGREGATE, 32'd3600, 64'd3600));
        push_item(make_item(CMD_AGGREGATE, 32'd3601, 64'd7200));
        push_item(make_item(CMD_AGGREGATE, 32'd86400, 64'h8000_0000_0000_0000));
        push_item(make_item(CMD_AGGREGATE, 32'd86401, 64'hffff_0000_ffff_0000));
        push_item(make_item(CMD_AGGREGATE, 32'd90000, 64'h7fff_ffff_ffff_ffff));

        // Random phases, each under its own window setting
        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            case (phase)
                1: begin short_val = 32'd1;               long_val = '1;    gap_max = 30;  end
                2: begin short_val = $urandom_range(2, 100);
                         long_val  = $urandom_range(100, 3000);            gap_max = 0;   end
                3: begin short_val = '1;                  long_val = 32'd1; gap_max = 400; end
                4: begin short_val = $urandom_range(1, 20);
                         long_val  = $urandom_range(20, 200);              gap_max = 30;  end
                default: begin short_val = SHORT_WINDOW_RESET;
                         long_val  = LONG_WINDOW_RESET;                    gap_max = 400; end
            endcase
            settle();
            write_windows(short_val, long_val);
            phase_start = samples_sent + resets_sent;
            while (samples_sent + resets_sent - phase_start < RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 6) != 0)
                    run_sequence();
                else
                    push_item(make_item($urandom_range(0, 3) == 0 ? CMD_RESET : CMD_AGGREGATE,
                                        $urandom, {$urandom, $urandom}));
            end
        end

        // Drain and verdict
        drop_valid();
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d samples and %0d reset commands across %0d window settings,",
                 samples_sent, resets_sent, NUM_PHASES + 1);
        $display("%0d config writes, %0d results checked, %0d samples with a full window.",
                 cfg_writes, checked, full_window_samples);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
